// ===== rtl/core/csf_pkg.sv =====
// csf_pkg: item types, command type, state encodings, byte constants and the
// whitespace test for the csv field splitter; no dependencies
package csf_pkg;

    localparam logic [7:0] QUOTE_CH   = 8'd34;
    localparam logic [7:0] COMMA_CH   = 8'd44;
    localparam logic [7:0] NEWLINE_CH = 8'd10;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_content;
        logic       row_end;
        logic       in_header;
        logic       truncated;
        logic       last_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_SPACE = 2'd0,
        OP_MARK  = 2'd1,
        OP_CHAR  = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic       row_end;
        logic       in_header;
        logic       truncated;
    } t_cmd;

    typedef enum logic [1:0] {
        QM_OUT   = 2'd0,
        QM_IN    = 2'd1,
        QM_AFTER = 2'd2
    } t_qmode;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_SEND = 2'd2,
        BK_LAST = 2'd3
    } t_back_state;

    function automatic logic is_space(input logic [7:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'd133 || c == 8'd160;
    endfunction

endpackage

// ===== rtl/core/csf_front.sv =====
// csf_front: accepts text items, tracks quoting and row state, issues commands
// depends on csf_pkg
module csf_front import csf_pkg::*; #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_data,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);
    localparam int CW = $clog2(PENDING_DEPTH + 1);

    logic          r_cfg;
    t_qmode        r_qmode, n_qmode;
    logic          r_row_open, n_row_open;
    logic          r_has, n_has;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_first, n_first;
    logic          r_hdr, n_hdr;
    logic          r_lost, n_lost;

    logic accept;
    logic cmd_valid;
    logic do_add, do_out, do_mark, mark_rend, hdr_now;
    logic [7:0] c;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && cmd_valid;
    assign c       = i_item.ch;

    always_comb begin
        n_qmode    = r_qmode;
        n_row_open = r_row_open;
        n_has      = r_has;
        n_cnt      = r_cnt;
        n_first    = r_first;
        n_hdr      = r_hdr;
        n_lost     = r_lost;
        cmd_valid  = 1'b0;
        o_cmd      = '{op: OP_SPACE, ch: c, row_end: 1'b0, in_header: r_hdr, truncated: r_lost};
        do_add     = 1'b0;
        do_out     = 1'b0;
        do_mark    = 1'b0;
        mark_rend  = 1'b0;
        hdr_now    = r_hdr;

        if (i_item.end_of_text || c == NEWLINE_CH) begin
            // close the line
            if (r_row_open) begin
                cmd_valid = 1'b1;
                o_cmd     = '{op: OP_MARK, ch: 8'd0, row_end: 1'b1, in_header: r_hdr,
                              truncated: r_lost};
                n_lost    = 1'b0;
            end
            n_row_open = 1'b0;
            n_hdr      = 1'b0;
            n_qmode    = QM_OUT;
            n_cnt      = '0;
            n_has      = 1'b0;
            n_first    = 1'b0;
            if (i_item.end_of_text) begin
                n_first = 1'b1;
                n_lost  = 1'b0;
            end
        end else if (r_row_open || !is_space(c)) begin
            if (!r_row_open) begin
                hdr_now    = r_first & r_cfg;
                n_row_open = 1'b1;
                n_hdr      = hdr_now;
            end
            unique case (r_qmode)
                QM_IN: begin
                    if (c == QUOTE_CH) n_qmode = QM_AFTER;
                    else               do_add  = 1'b1;
                end
                QM_AFTER: begin
                    if (c == QUOTE_CH) begin
                        do_add  = 1'b1;
                        n_qmode = QM_IN;
                    end else begin
                        do_out  = 1'b1;
                    end
                end
                default: do_out = 1'b1;
            endcase
            if (do_out) begin
                n_qmode = QM_OUT;
                if (c == QUOTE_CH)      n_qmode = QM_IN;
                else if (c == COMMA_CH) do_mark = 1'b1;
                else                    do_add  = 1'b1;
            end
            if (do_mark) begin
                cmd_valid = 1'b1;
                o_cmd     = '{op: OP_MARK, ch: 8'd0, row_end: mark_rend, in_header: hdr_now,
                              truncated: r_lost};
                n_lost    = 1'b0;
                n_cnt     = '0;
                n_has     = 1'b0;
            end
            if (do_add) begin
                if (is_space(c)) begin
                    // interior whitespace is held until content follows
                    if (r_has) begin
                        if (r_cnt < CW'(PENDING_DEPTH)) begin
                            cmd_valid = 1'b1;
                            o_cmd     = '{op: OP_SPACE, ch: c, row_end: 1'b0,
                                          in_header: hdr_now, truncated: 1'b0};
                            n_cnt     = r_cnt + CW'(1);
                        end else begin
                            n_lost = 1'b1;
                        end
                    end
                end else begin
                    cmd_valid = 1'b1;
                    o_cmd     = '{op: OP_CHAR, ch: c, row_end: 1'b0, in_header: hdr_now,
                                  truncated: r_lost};
                    n_lost    = 1'b0;
                    n_cnt     = '0;
                    n_has     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= 1'b0;
            r_qmode    <= QM_OUT;
            r_row_open <= 1'b0;
            r_has      <= 1'b0;
            r_cnt      <= '0;
            r_first    <= 1'b1;
            r_hdr      <= 1'b0;
            r_lost     <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (accept) begin
                r_qmode    <= n_qmode;
                r_row_open <= n_row_open;
                r_has      <= n_has;
                r_cnt      <= n_cnt;
                r_first    <= n_first;
                r_hdr      <= n_hdr;
                r_lost     <= n_lost;
            end
        end
    end

endmodule

// ===== rtl/core/csf_queue.sv =====
// csf_queue: two-entry command queue between front and back
// depends on csf_pkg
module csf_queue import csf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);
    t_cmd       r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/csf_back.sv =====
// csf_back: holds trailing whitespace, executes commands, drives result register
// depends on csf_pkg
module csf_back import csf_pkg::*; #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    t_back_state   r_state, n_state;
    logic [7:0]    r_mem [PENDING_DEPTH];
    logic [7:0]    r_rdata;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_rd;
    t_cmd          r_cur;
    logic          r_trunc;
    logic          r_ovalid;
    t_out_item     r_out;

    logic      slot_free;
    logic      load;
    t_out_item load_item;
    logic      cnt_clr, cnt_inc, rd_inc, start_flush, trunc_clr;

    assign slot_free = !r_ovalid || i_ready;
    assign o_valid   = r_ovalid;
    assign o_item    = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (o_pop && i_cmd.op == OP_CHAR && r_cnt != '0) n_state = BK_READ;
            BK_READ: n_state = BK_SEND;
            BK_SEND: begin
                if (slot_free) n_state = (r_rd + CW'(1) == r_cnt) ? BK_LAST : BK_READ;
            end
            BK_LAST: if (slot_free) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop       = 1'b0;
        load        = 1'b0;
        load_item   = '0;
        cnt_clr     = 1'b0;
        cnt_inc     = 1'b0;
        rd_inc      = 1'b0;
        start_flush = 1'b0;
        trunc_clr   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_pop = !i_empty && (i_cmd.op == OP_SPACE || slot_free);
                if (o_pop) begin
                    unique case (i_cmd.op)
                        OP_SPACE: cnt_inc = 1'b1;
                        OP_MARK: begin
                            load      = 1'b1;
                            load_item = '{out_char: 8'd0, is_content: 1'b0,
                                          row_end: i_cmd.row_end, in_header: i_cmd.in_header,
                                          truncated: i_cmd.truncated, last_of_run: 1'b1};
                            cnt_clr   = 1'b1;
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                load      = 1'b1;
                                load_item = '{out_char: i_cmd.ch, is_content: 1'b1,
                                              row_end: 1'b0, in_header: i_cmd.in_header,
                                              truncated: i_cmd.truncated, last_of_run: 1'b1};
                            end else begin
                                start_flush = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_READ: ;
            BK_SEND: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_item = '{out_char: r_rdata, is_content: 1'b1, row_end: 1'b0,
                                  in_header: r_cur.in_header, truncated: r_trunc,
                                  last_of_run: 1'b0};
                    rd_inc    = 1'b1;
                    trunc_clr = 1'b1;
                end
            end
            default: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_item = '{out_char: r_cur.ch, is_content: 1'b1, row_end: 1'b0,
                                  in_header: r_cur.in_header, truncated: r_trunc,
                                  last_of_run: 1'b1};
                    cnt_clr   = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == OP_SPACE) r_mem[r_cnt[AW-1:0]] <= i_cmd.ch;
        r_rdata <= r_mem[r_rd[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= load_item;
        if (start_flush) r_cur <= i_cmd;
        if (start_flush)    r_trunc <= i_cmd.truncated;
        else if (trunc_clr) r_trunc <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_cnt    <= '0;
            r_rd     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cnt_clr)      r_cnt <= '0;
            else if (cnt_inc) r_cnt <= r_cnt + CW'(1);
            if (start_flush)  r_rd <= '0;
            else if (rd_inc)  r_rd <= r_rd + CW'(1);
            if (load)         r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/csv_field_splitter.sv =====
// csv_field_splitter: top level, front classifier, command queue, back emitter
// depends on csf_pkg, csf_front, csf_queue, csf_back
//
// usage
//   input channel: i_valid / o_ready with i_item {ch, end_of_text}, one text
//     byte per item; end_of_text closes the final line and returns to text start
//   output channel: o_valid / i_ready with o_item, content bytes and
//     end-of-field markers; last_of_run flags the final result of each item
//   config: i_cfg_we / i_cfg_data write first_row_is_headers, only while idle
//   throughput: one item per cycle while the queue has room; a content byte
//     that releases held whitespace bytes occupies the back end while each one is
//     read from the whitespace buffer, a registered read, and then sent
//   path: an accepted item's command, if any, is written into the queue; when the back end
//     is free it pops the command and, for a marker or content byte, loads the output
//     register, raising o_valid; a released whitespace run passes through the registered buffer read first
//   reset: synchronous, active low; clears quoting, row and header state and
//     the queue; the whitespace buffer needs no clearing
//   stall: a stalled receiver holds the output register, the back end stops but
//     still takes held whitespace, the two-entry queue fills and o_ready then drops
module csv_field_splitter import csf_pkg::*; #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    // front to queue
    t_cmd front_cmd;
    logic q_push;
    logic q_full;
    // queue to back
    t_cmd queue_cmd;
    logic q_pop;
    logic q_empty;

    csf_front #(.PENDING_DEPTH(PENDING_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    // short queue so front and back stall independently
    csf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (queue_cmd),
        .o_empty (q_empty)
    );

    // back end owns the held whitespace buffer and the output register
    csf_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (queue_cmd),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("command pushed into full queue");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("command popped from empty queue");

    // a field-end marker carries no byte and closes its item's run
    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.is_content) |-> (o_item.out_char == 8'd0 && o_item.last_of_run))
        else $error("malformed end-of-field marker");

    // nothing is shown right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid) else $error("output valid after reset");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench for csv_field_splitter, with a scoreboard class
// that predicts the field bytes and markers; depends on csf_pkg and the rtl top
module tb;
    import csf_pkg::*;

    localparam int HELD_MAX     = 32;
    localparam int SETTLE_WAIT  = 16;
    localparam int TAIL_WAIT    = 80;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_LINES    = 50;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_cfg_we   = 1'b0;
    logic      i_cfg_data = 1'b0;
    logic      i_valid    = 1'b0;
    t_in_item  i_item     = '0;
    logic      i_ready    = 1'b0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_item;

    // whitespace as the splitter trims it: tab to carriage return, space, nel, nbsp
    function automatic bit is_blank(input logic [7:0] c);
        case (c)
            8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32, 8'd133, 8'd160: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // field splitter prediction plus the queue of results still owed
    class splitter_scoreboard;
        bit              hdr_cfg;
        t_qmode          qmode;
        bit              row_open;
        bit              field_live;
        logic [7:0]      held_ws[$];
        bit              first_line;
        bit              hdr_row;
        bit              ws_lost;
        t_out_item       owed_q[$];
        int              errors;

        function new();
            qmode      = QM_OUT;
            first_line = 1'b1;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        task report(input string what);
            if (errors < MAX_LINES)
                $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void emit(input logic [7:0] c, input bit content, input bit rend);
            t_out_item r;
            r.out_char    = c;
            r.is_content  = content;
            r.row_end     = rend;
            r.in_header   = hdr_row;
            r.truncated   = ws_lost;
            r.last_of_run = 1'b0;
            ws_lost = 1'b0;
            owed_q.push_back(r);
        endfunction

        function void end_field(input bit rend);
            emit(8'd0, 1'b0, rend);
            held_ws.delete();
            field_live = 1'b0;
        endfunction

        function void add_byte(input logic [7:0] c);
            if (is_blank(c)) begin
                if (!field_live)
                    return;
                if (held_ws.size() < HELD_MAX)
                    held_ws.push_back(c);
                else
                    ws_lost = 1'b1;
                return;
            end
            foreach (held_ws[i])
                emit(held_ws[i], 1'b1, 1'b0);
            held_ws.delete();
            emit(c, 1'b1, 1'b0);
            field_live = 1'b1;
        endfunction

        function void plain_byte(input logic [7:0] c);
            qmode = QM_OUT;
            if (c == QUOTE_CH)
                qmode = QM_IN;
            else if (c == COMMA_CH)
                end_field(1'b0);
            else
                add_byte(c);
        endfunction

        function void close_line();
            if (row_open)
                end_field(1'b1);
            row_open   = 1'b0;
            hdr_row    = 1'b0;
            qmode      = QM_OUT;
            held_ws.delete();
            field_live = 1'b0;
            first_line = 1'b0;
        endfunction

        // work out the results one accepted item causes
        function void note_input(input t_in_item it);
            int base;
            base = owed_q.size();
            if (it.end_of_text) begin
                close_line();
                first_line = 1'b1;
                ws_lost    = 1'b0;
            end else if (it.ch == NEWLINE_CH) begin
                close_line();
            end else begin
                if (!row_open) begin
                    if (is_blank(it.ch))
                        return;
                    row_open = 1'b1;
                    hdr_row  = first_line & hdr_cfg;
                end
                case (qmode)
                    QM_IN: begin
                        if (it.ch == QUOTE_CH)
                            qmode = QM_AFTER;
                        else
                            add_byte(it.ch);
                    end
                    QM_AFTER: begin
                        if (it.ch == QUOTE_CH) begin
                            add_byte(it.ch);
                            qmode = QM_IN;
                        end else begin
                            plain_byte(it.ch);
                        end
                    end
                    default: plain_byte(it.ch);
                endcase
            end
            if (owed_q.size() > base)
                owed_q[owed_q.size() - 1].last_of_run = 1'b1;
        endfunction

        task check_result(input t_out_item got);
            t_out_item want;
            if (owed_q.size() == 0) begin
                report($sformatf("result %h with nothing owed", got));
                return;
            end
            want = owed_q.pop_front();
            if (got.out_char !== want.out_char)
                report($sformatf("out_char %0d, want %0d", got.out_char, want.out_char));
            if (got.is_content !== want.is_content)
                report($sformatf("is_content %b, want %b", got.is_content, want.is_content));
            if (got.row_end !== want.row_end)
                report($sformatf("row_end %b, want %b", got.row_end, want.row_end));
            if (got.in_header !== want.in_header)
                report($sformatf("in_header %b, want %b", got.in_header, want.in_header));
            if (got.truncated !== want.truncated)
                report($sformatf("truncated %b, want %b", got.truncated, want.truncated));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %b, want %b", got.last_of_run,
                                 want.last_of_run));
        endtask
    endclass

    splitter_scoreboard sb = new();

    t_in_item script_q[$];
    bit       calm        = 1'b0;
    bit       src_idle_on = 1'b1;
    int       stall_left  = 0;
    int       quiet_left  = 0;
    int       cycle_count = 0;

    csv_field_splitter #(
        .PENDING_DEPTH(HELD_MAX)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // every accepted result goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_item);
    end

    // receiver: random stall bursts, with stall-free stretches between
    always @(negedge i_clk) begin
        if (calm || quiet_left > 0) begin
            if (quiet_left > 0)
                quiet_left--;
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    stall_left = $urandom_range(0, 4);
                    i_ready <= 1'b0;
                end
                2: begin
                    quiet_left = $urandom_range(20, 60);
                    i_ready <= 1'b1;
                end
                default: i_ready <= 1'b1;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // text building
    // ---------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] c);
        t_in_item it;
        it.ch          = c;
        it.end_of_text = 1'b0;
        script_q.push_back(it);
    endfunction

    // end of text; the byte rides along and should be ignored
    function automatic void push_eot(input logic [7:0] c);
        t_in_item it;
        it.ch          = c;
        it.end_of_text = 1'b1;
        script_q.push_back(it);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 6))
            0: return 8'd9;
            1: return 8'd11;
            2: return 8'd12;
            3: return 8'd13;
            4: return 8'd133;
            5: return 8'd160;
            default: return 8'd32;
        endcase
    endfunction

    // any byte that is not a quote, comma, newline or whitespace
    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == QUOTE_CH || c == COMMA_CH || is_blank(c))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic void push_blanks(input int n);
        for (int i = 0; i < n; i++)
            push_byte(pick_blank());
    endfunction

    // one field: optional padding, quoted or bare, doubled quotes, commas in quotes,
    // now and then a whitespace run that may overflow the held buffer
    function automatic void push_field(input bit broken);
        bit quoted;
        int n;
        quoted = ($urandom_range(0, 2) == 0);
        push_blanks($urandom_range(0, 2));
        if (quoted)
            push_byte(QUOTE_CH);
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                6: push_byte(pick_blank());
                7: begin
                    if (quoted) begin
                        push_byte(QUOTE_CH);
                        push_byte(QUOTE_CH);
                    end else begin
                        push_byte(pick_plain());
                    end
                end
                8: push_byte(quoted ? COMMA_CH : pick_blank());
                default: push_byte(pick_plain());
            endcase
        end
        if ($urandom_range(0, 39) == 0) begin
            push_byte(pick_plain());
            push_blanks($urandom_range(30, 36));
            if ($urandom_range(0, 1) == 0)
                push_byte(pick_plain());
        end
        if (quoted && !broken) begin
            push_byte(QUOTE_CH);
            if ($urandom_range(0, 5) == 0)
                push_byte(pick_plain());
        end
        push_blanks($urandom_range(0, 2));
    endfunction

    function automatic void push_random_line();
        int n;
        bit broken;
        case ($urandom_range(0, 9))
            0: begin
                // noise, any byte at all
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(0, 255)));
            end
            1: push_blanks($urandom_range(0, 3));
            default: begin
                n = $urandom_range(1, 4);
                broken = ($urandom_range(0, 9) == 0);
                for (int f = 0; f < n; f++) begin
                    if (f > 0)
                        push_byte(COMMA_CH);
                    push_field(broken && f == n - 1);
                end
            end
        endcase
        if ($urandom_range(0, 7) == 0)
            push_eot(8'($urandom_range(0, 255)));
        else
            push_byte(NEWLINE_CH);
    endfunction

    // ---------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------
    task automatic send_item(input t_in_item it);
        int gap;
        if (!calm && src_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_input(it);
    endtask

    // play the queued text; the last calm_tail items run with no idling
    task automatic play_script(input int calm_tail);
        t_in_item it;
        while (script_q.size() > 0) begin
            if (script_q.size() <= calm_tail)
                calm = 1'b1;
            it = script_q.pop_front();
            if (it.end_of_text || it.ch == NEWLINE_CH)
                src_idle_on = ($urandom_range(0, 3) != 0);
            send_item(it);
        end
    endtask

    // hold the sender until every owed result has come out
    task automatic wait_all_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // idle the block fully, then write first_row_is_headers
    task automatic write_cfg(input bit hdr);
        wait_all_results();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= hdr;
        sb.hdr_cfg = hdr;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed text, header marking on
        write_cfg(1'b1);
        // header line: extreme bytes, padding, doubled quote, byte after a closing quote
        push_byte(8'h00);
        push_text("1, \"q\"\"x\"y ,z");
        push_byte(8'hFF);
        push_byte(8'd133);
        push_byte(NEWLINE_CH);
        // quote still open at line end, comma and nbsp inside quotes
        push_text("\"a");
        push_byte(8'd160);
        push_text("b,");
        push_byte(NEWLINE_CH);
        // whitespace-only line
        push_byte(8'd9);
        push_byte(8'd32);
        push_byte(8'd13);
        push_byte(NEWLINE_CH);
        // end of text on an empty line, then a new text whose first line is a header
        push_eot(8'hFF);
        push_text("k");
        push_eot(NEWLINE_CH);
        // held whitespace overflow released by content, then overflow before a marker
        push_text("a");
        push_blanks(HELD_MAX + 1);
        push_text("b");
        push_blanks(HELD_MAX + 2);
        push_byte(COMMA_CH);
        push_byte(NEWLINE_CH);
        play_script(0);

        // random text, header marking off, sender held once mid-run
        write_cfg(1'b0);
        while (script_q.size() < 15)
            push_random_line();
        play_script(0);
        wait_all_results();
        while (script_q.size() < 15)
            push_random_line();
        play_script(0);

        // random text, header marking on, opening at text start; quiet tail
        write_cfg(1'b1);
        push_eot(8'($urandom_range(0, 255)));
        while (script_q.size() < 35)
            push_random_line();
        play_script(15);

        wait_all_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
